// ===== rtl/sscv_pkg.sv =====
`default_nettype none
package sscv_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int MAX_HALF    = 4;
    localparam int NUM_TAPS    = MAX_HALF + 1;
    localparam int WIN_LEN     = 2 * MAX_HALF + 1;
    localparam int WIN_IDX_W   = $clog2(WIN_LEN);
    localparam int PIX_BITS    = 16;
    localparam int COEF_BITS   = 16;
    localparam int COEF_FRAC   = 14;
    localparam int ROW_W       = 13;
    localparam int ROWP_W      = ROW_W + 1;
    localparam int CCOL_W      = 11;
    localparam int HALF_W      = 3;
    localparam int KIDX_W      = $clog2(NUM_TAPS);
    localparam int SLOT_W      = $clog2(2 * MAX_HALF);
    localparam int ADDR_W      = SLOT_W + COL_W;
    localparam int STORE_DEPTH = 2 * MAX_HALF * MAX_COLS;
    localparam int SUM_W       = PIX_BITS + 1;
    localparam int PROD_W      = COEF_BITS + SUM_W;
    localparam int ACC_W       = PROD_W + 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DAT_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF3  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEF4  = 3'd7;

    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_SHIFT = 4'd1;
    localparam logic [3:0] OP_HMAC  = 4'd2;
    localparam logic [3:0] OP_HRND  = 4'd3;
    localparam logic [3:0] OP_VXA   = 4'd4;
    localparam logic [3:0] OP_VRA   = 4'd5;
    localparam logic [3:0] OP_VXB   = 4'd6;
    localparam logic [3:0] OP_VRB   = 4'd7;
    localparam logic [3:0] OP_VMAC  = 4'd8;
    localparam logic [3:0] OP_FIN   = 4'd9;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) << (PIX_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO   = ~SAT_HI;

    typedef struct packed {
        logic [ROW_W-1:0]                     img_rows;
        logic [CCOL_W-1:0]                    img_cols;
        logic [HALF_W-1:0]                    half_size;
        logic [NUM_TAPS-1:0][COEF_BITS-1:0]   coef;
    } t_cfg;

    typedef struct packed {
        logic [3:0]                  op;
        logic signed [PIX_BITS-1:0]  pix;
        logic [KIDX_W-1:0]           k;
        logic [COL_W-1:0]            j;
        logic [COL_W-1:0]            c;
        logic [COL_W-1:0]            hi;
        logic [ROW_W-1:0]            row_r;
        logic [ROW_W-1:0]            orow;
        logic                        has_cur;
        logic                        emit;
        logic                        wr;
        logic                        last;
        logic                        done;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic [ROW_W-1:0] eff_rows(input t_cfg cfg);
        return (cfg.img_rows == '0) ? ROW_W'(1) : cfg.img_rows;
    endfunction

    function automatic logic [CCOL_W-1:0] eff_cols(input t_cfg cfg);
        logic [CCOL_W-1:0] c;
        c = (cfg.img_cols == '0) ? CCOL_W'(1) : cfg.img_cols;
        if (c > CCOL_W'(MAX_COLS)) c = CCOL_W'(MAX_COLS);
        return c;
    endfunction

    function automatic logic [HALF_W-1:0] eff_half(input t_cfg cfg);
        return (cfg.half_size > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : cfg.half_size;
    endfunction

    function automatic logic signed [PIX_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        t = (acc + RND_HALF) >>> COEF_FRAC;
        if (t > SAT_HI) t = SAT_HI;
        if (t < SAT_LO) t = SAT_LO;
        return t[PIX_BITS-1:0];
    endfunction

    // line store slot of a row: row mod 2h; mod 6 through a reciprocal of three
    function automatic logic [SLOT_W-1:0] slot_of(input logic [ROW_W-1:0] x,
                                                  input logic [HALF_W-1:0] h);
        logic [ROW_W+15:0] prod;
        logic [ROW_W-2:0]  q;
        logic [ROW_W:0]    q3;
        logic [ROW_W:0]    rem;
        logic [SLOT_W-1:0] m;
        prod = {16'd0, x} * {{ROW_W{1'b0}}, 16'd43691};
        q    = prod[ROW_W+15:17];
        q3   = {1'b0, q, 1'b0} + {2'b0, q};
        rem  = {1'b0, x} - q3;
        m    = (rem[0] == x[0]) ? {1'b0, rem[1:0]} : ({1'b0, rem[1:0]} + SLOT_W'(3));
        case (h)
            3'd1:    return {2'b0, x[0]};
            3'd2:    return {1'b0, x[1:0]};
            3'd3:    return m;
            3'd4:    return x[2:0];
            default: return '0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sscv_in_if.sv =====
`default_nettype none
interface sscv_in_if;
    import sscv_pkg::*;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic signed [PIX_BITS-1:0]  pixel_in;
    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/sscv_out_if.sv =====
`default_nettype none
interface sscv_out_if;
    import sscv_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [PIX_BITS-1:0]  pixel_out;
    logic                        run_last;
    logic                        frame_done;
    modport source (output valid, output pixel_out, output run_last, output frame_done,
                    input ready);
    modport sink   (input valid, input pixel_out, input run_last, input frame_done,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/sscv_cfg_if.sv =====
`default_nettype none
interface sscv_cfg_if;
    import sscv_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DAT_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sscv_dp.sv =====
`default_nettype none
module sscv_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sscv_pkg::t_cfg                 i_cfg,
    input  sscv_pkg::t_cmd                 i_cmd,
    output sscv_pkg::t_sts                 o_sts,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic signed [sscv_pkg::PIX_BITS-1:0] o_pixel_out,
    output logic                           o_run_last,
    output logic                           o_frame_done
);
    import sscv_pkg::*;

    logic signed [PIX_BITS-1:0] r_win [WIN_LEN];
    logic signed [PIX_BITS-1:0] r_mem [STORE_DEPTH];
    logic signed [PIX_BITS-1:0] r_rd;
    logic signed [PIX_BITS-1:0] r_va;
    logic signed [PIX_BITS-1:0] r_hv;
    logic [ROW_W-1:0]           r_x;
    logic [ROW_W-1:0]           r_xa;
    logic [ROW_W-1:0]           r_xb;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_ovalid;
    logic signed [PIX_BITS-1:0] r_opix;
    logic                       r_olast;
    logic                       r_odone;

    logic [ROW_W-1:0]           rows_m1;
    logic [HALF_W-1:0]          h;
    logic signed [COL_W+1:0]    xa;
    logic signed [COL_W+1:0]    xb;
    logic signed [PIX_BITS-1:0] wa;
    logic signed [PIX_BITS-1:0] wb;
    logic [ROW_W-1:0]           row_a;
    logic [ROW_W-1:0]           row_b;
    logic signed [PIX_BITS-1:0] sel_a;
    logic signed [PIX_BITS-1:0] sel_b;
    logic signed [SUM_W-1:0]    sum;
    logic signed [COEF_BITS-1:0] tap;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    acc_next;
    logic [ADDR_W-1:0]          raddr;
    logic [ADDR_W-1:0]          waddr;
    logic                       re;
    logic                       we;

    function automatic logic [WIN_IDX_W-1:0] win_idx(input logic signed [COL_W+1:0] x,
                                                     input logic [COL_W-1:0] hi,
                                                     input logic [COL_W-1:0] c);
        logic signed [COL_W+1:0] xc;
        logic signed [COL_W+2:0] d;
        xc = x;
        if (xc > $signed({2'b0, hi})) xc = $signed({2'b0, hi});
        if (xc < 0) xc = '0;
        d = $signed({3'b0, c}) - $signed({xc[COL_W+1], xc});
        if (d < 0) d = '0;
        if (d > $signed((COL_W+3)'(WIN_LEN - 1))) d = (COL_W+3)'(WIN_LEN - 1);
        return d[WIN_IDX_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] clamp_row(input logic signed [ROW_W+1:0] v,
                                                   input logic [ROW_W-1:0] mx);
        if (v < 0) return '0;
        if (v > $signed({2'b0, mx})) return mx;
        return v[ROW_W-1:0];
    endfunction

    always_comb begin
        rows_m1 = eff_rows(i_cfg) - ROW_W'(1);
        h       = eff_half(i_cfg);
        xa      = $signed({2'b0, i_cmd.j}) + $signed({{(COL_W+2-KIDX_W){1'b0}}, i_cmd.k});
        xb      = $signed({2'b0, i_cmd.j}) - $signed({{(COL_W+2-KIDX_W){1'b0}}, i_cmd.k});
        wa      = r_win[win_idx(xa, i_cmd.hi, i_cmd.c)];
        wb      = r_win[win_idx(xb, i_cmd.hi, i_cmd.c)];
        row_a   = clamp_row($signed({2'b0, i_cmd.orow}) +
                            $signed({{(ROW_W+2-KIDX_W){1'b0}}, i_cmd.k}), rows_m1);
        row_b   = clamp_row($signed({2'b0, i_cmd.orow}) -
                            $signed({{(ROW_W+2-KIDX_W){1'b0}}, i_cmd.k}), rows_m1);
        sel_a   = (i_cmd.has_cur && r_xa == i_cmd.row_r) ? r_hv : r_rd;
        sel_b   = (i_cmd.has_cur && r_xb == i_cmd.row_r) ? r_hv : r_rd;
        if (i_cmd.op == OP_HMAC) begin
            sum = (i_cmd.k == '0) ? SUM_W'(wa) : (SUM_W'(wa) + SUM_W'(wb));
        end else begin
            sum = (i_cmd.k == '0) ? SUM_W'(r_va) : (SUM_W'(r_va) + SUM_W'(sel_b));
        end
        tap      = $signed(i_cfg.coef[i_cmd.k]);
        prod     = PROD_W'(tap) * PROD_W'(sum);
        acc_next = ((i_cmd.k == '0) ? '0 : r_acc) + ACC_W'(prod);
        raddr    = {slot_of(r_x, h), i_cmd.j};
        waddr    = {slot_of(i_cmd.row_r, h), i_cmd.j};
        re       = (i_cmd.op == OP_VRA) || (i_cmd.op == OP_VRB);
        we       = (i_cmd.op == OP_FIN) && i_cmd.wr;
        o_sts.out_free = !r_ovalid || i_out_ready;
    end

    // pixel window, newest pixel in entry zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_LEN; i++) r_win[i] <= '0;
        end else if (i_cmd.op == OP_SHIFT) begin
            r_win[0] <= i_cmd.pix;
            for (int i = 1; i < WIN_LEN; i++) r_win[i] <= r_win[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= r_hv;
        if (re) r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_HMAC: r_acc <= acc_next;
            OP_VMAC: r_acc <= acc_next;
            OP_HRND: r_hv  <= round_sat(r_acc);
            OP_VXA:  r_x   <= row_a;
            OP_VRA:  r_xa  <= r_x;
            OP_VXB: begin
                r_va <= sel_a;
                r_x  <= row_b;
            end
            OP_VRB:  r_xb  <= r_x;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_FIN && i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FIN && i_cmd.emit) begin
            r_opix  <= round_sat(r_acc);
            r_olast <= i_cmd.last;
            r_odone <= i_cmd.done;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_pixel_out  = r_opix;
    assign o_run_last   = r_olast;
    assign o_frame_done = r_odone;

endmodule
`default_nettype wire

// ===== rtl/sscv_ctrl.sv =====
`default_nettype none
module sscv_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sscv_pkg::t_cfg        i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_req_type,
    input  logic signed [sscv_pkg::PIX_BITS-1:0] i_pixel_in,
    input  sscv_pkg::t_sts        i_sts,
    output sscv_pkg::t_cmd        o_cmd
);
    import sscv_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HMAC = 4'd1;
    localparam logic [3:0] S_HRND = 4'd2;
    localparam logic [3:0] S_VXA  = 4'd3;
    localparam logic [3:0] S_VRA  = 4'd4;
    localparam logic [3:0] S_VXB  = 4'd5;
    localparam logic [3:0] S_VRB  = 4'd6;
    localparam logic [3:0] S_VMAC = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [ROWP_W-1:0]   r_row,   n_row;
    logic [COL_W-1:0]    r_col,   n_col;
    logic [ROW_W-1:0]    r_rr,    n_rr;
    logic [COL_W-1:0]    r_c,     n_c;
    logic [COL_W-1:0]    r_hi,    n_hi;
    logic [COL_W-1:0]    r_j,     n_j;
    logic [COL_W-1:0]    r_jhi,   n_jhi;
    logic [KIDX_W-1:0]   r_k,     n_k;
    logic                r_drain, n_drain;
    logic                r_emit,  n_emit;
    logic [ROW_W-1:0]    r_orow,  n_orow;

    logic [ROW_W-1:0]         rows;
    logic [CCOL_W-1:0]        cols;
    logic [HALF_W-1:0]        h;
    logic [COL_W-1:0]         colsm1;
    logic                     wrap;
    logic [ROW_W-1:0]         rowp;
    logic [COL_W-1:0]         colp;
    logic                     last_p;
    logic signed [COL_W+1:0]  jlo_s;
    logic signed [COL_W+1:0]  jhi_s;
    logic                     any_col;
    logic                     in_rng;
    logic signed [ROWP_W:0]   orow_d;
    logic [COL_W-1:0]         c_d;

    always_comb begin
        rows   = eff_rows(i_cfg);
        cols   = eff_cols(i_cfg);
        h      = eff_half(i_cfg);
        colsm1 = COL_W'(cols - CCOL_W'(1));

        wrap   = r_row >= {1'b0, rows};
        rowp   = wrap ? '0 : r_row[ROW_W-1:0];
        colp   = wrap ? '0 : r_col;
        last_p = colp >= colsm1;
        jlo_s  = $signed({2'b0, colp}) - $signed({{(COL_W+2-HALF_W){1'b0}}, h});
        jhi_s  = last_p ? $signed({2'b0, colsm1}) : jlo_s;
        if (jlo_s > jhi_s) jlo_s = jhi_s;
        if (jlo_s < 0) jlo_s = '0;
        any_col = jlo_s <= jhi_s;

        in_rng = (r_row >= {1'b0, rows}) &&
                 ({1'b0, r_row} < ({2'b0, rows} + {{(ROWP_W+1-HALF_W){1'b0}}, h}));
        orow_d = $signed({1'b0, r_row}) - $signed({{(ROWP_W+1-HALF_W){1'b0}}, h});
        c_d    = (r_col > colsm1) ? colsm1 : r_col;

        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_rr    = r_rr;
        n_c     = r_c;
        n_hi    = r_hi;
        n_j     = r_j;
        n_jhi   = r_jhi;
        n_k     = r_k;
        n_drain = r_drain;
        n_emit  = r_emit;
        n_orow  = r_orow;

        o_in_ready    = (r_state == S_IDLE);
        o_cmd.op      = OP_NONE;
        o_cmd.pix     = i_pixel_in;
        o_cmd.k       = r_k;
        o_cmd.j       = r_j;
        o_cmd.c       = r_c;
        o_cmd.hi      = r_hi;
        o_cmd.row_r   = r_rr;
        o_cmd.orow    = r_orow;
        o_cmd.has_cur = !r_drain;
        o_cmd.emit    = r_emit;
        o_cmd.wr      = !r_drain && (h != '0);
        o_cmd.last    = (r_j == r_jhi);
        o_cmd.done    = (r_orow == rows - ROW_W'(1)) && (r_j == colsm1);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_req_type) begin
                        o_cmd.op = OP_SHIFT;
                        n_rr     = rowp;
                        n_c      = colp;
                        n_hi     = last_p ? colsm1 : colp;
                        n_j      = jlo_s[COL_W-1:0];
                        n_jhi    = jhi_s[COL_W-1:0];
                        n_k      = '0;
                        n_drain  = 1'b0;
                        n_row    = last_p ? ROWP_W'(rowp) + ROWP_W'(1) : ROWP_W'(rowp);
                        n_col    = last_p ? '0 : colp + COL_W'(1);
                        n_state  = any_col ? S_HMAC : S_IDLE;
                    end else if (in_rng) begin
                        n_row = (c_d >= colsm1) ? r_row + ROWP_W'(1) : r_row;
                        n_col = (c_d >= colsm1) ? '0 : c_d + COL_W'(1);
                        if (orow_d >= 0) begin
                            n_drain = 1'b1;
                            n_emit  = 1'b1;
                            n_orow  = orow_d[ROW_W-1:0];
                            n_j     = c_d;
                            n_jhi   = c_d;
                            n_k     = '0;
                            n_state = S_VXA;
                        end
                    end
                end
            end
            S_HMAC: begin
                o_cmd.op = OP_HMAC;
                if (HALF_W'(r_k) == h) begin
                    n_k     = '0;
                    n_state = S_HRND;
                end else begin
                    n_k = r_k + KIDX_W'(1);
                end
            end
            S_HRND: begin
                o_cmd.op = OP_HRND;
                if (r_rr >= ROW_W'(h)) begin
                    n_orow  = r_rr - ROW_W'(h);
                    n_emit  = 1'b1;
                    n_state = S_VXA;
                end else begin
                    n_emit  = 1'b0;
                    n_state = S_FIN;
                end
            end
            S_VXA: begin
                o_cmd.op = OP_VXA;
                n_state  = S_VRA;
            end
            S_VRA: begin
                o_cmd.op = OP_VRA;
                n_state  = S_VXB;
            end
            S_VXB: begin
                o_cmd.op = OP_VXB;
                n_state  = S_VRB;
            end
            S_VRB: begin
                o_cmd.op = OP_VRB;
                n_state  = S_VMAC;
            end
            S_VMAC: begin
                o_cmd.op = OP_VMAC;
                if (HALF_W'(r_k) == h) begin
                    n_k     = '0;
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + KIDX_W'(1);
                    n_state = S_VXA;
                end
            end
            S_FIN: begin
                // hold while the output register is still full
                if (!r_emit || i_sts.out_free) begin
                    o_cmd.op = OP_FIN;
                    if (r_j == r_jhi) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + COL_W'(1);
                        n_k     = '0;
                        n_state = S_HMAC;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_drain <= 1'b0;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_drain <= n_drain;
            r_emit  <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rr   <= n_rr;
        r_c    <= n_c;
        r_hi   <= n_hi;
        r_j    <= n_j;
        r_jhi  <= n_jhi;
        r_k    <= n_k;
        r_orow <= n_orow;
    end

endmodule
`default_nettype wire

// ===== rtl/symmetric_separable_convolve.sv =====
`default_nettype none
// Channel   Dir   Payload                           Transfer
// i_pix     in    req_type, pixel_in                valid & ready
// o_res     out   pixel_out, run_last, frame_done   valid & ready
// i_cfg     in    index, data                       valid & ready (ready always high)
//
// A pixel is accepted only when idle; for each column it completes, there follow the
// horizontal multiply-accumulate over the taps, a rounding step, the column taps (only
// from row h on, where the column yields a result) and a finishing step; a drain tick
// runs the column taps and a finishing step. The single shared multiplier and the one-port
// line store read (two reads per column tap) make these steps run one after another.
// Reset clears position, control and window; the line store needs no clearing pass.
// A full output register holds the finishing cycle until the result is taken.
module symmetric_separable_convolve (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sscv_in_if.sink      i_pix,
    sscv_out_if.source   o_res,
    sscv_cfg_if.sink     i_cfg
);
    import sscv_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.img_rows  <= ROW_W'(1);
            r_cfg.img_cols  <= CCOL_W'(1);
            r_cfg.half_size <= '0;
            r_cfg.coef      <= (NUM_TAPS*COEF_BITS)'(1 << COEF_FRAC);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ROWS:  r_cfg.img_rows  <= i_cfg.data[ROW_W-1:0];
                REG_COLS:  r_cfg.img_cols  <= i_cfg.data[CCOL_W-1:0];
                REG_HALF:  r_cfg.half_size <= i_cfg.data[HALF_W-1:0];
                REG_COEF0: r_cfg.coef[0]   <= i_cfg.data[COEF_BITS-1:0];
                REG_COEF1: r_cfg.coef[1]   <= i_cfg.data[COEF_BITS-1:0];
                REG_COEF2: r_cfg.coef[2]   <= i_cfg.data[COEF_BITS-1:0];
                REG_COEF3: r_cfg.coef[3]   <= i_cfg.data[COEF_BITS-1:0];
                REG_COEF4: r_cfg.coef[4]   <= i_cfg.data[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    sscv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_req_type (i_pix.req_type),
        .i_pixel_in (i_pix.pixel_in),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sscv_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_pixel_out  (o_res.pixel_out),
        .o_run_last   (o_res.run_last),
        .o_frame_done (o_res.frame_done)
    );

endmodule
`default_nettype wire
